>>> rtl/atvo_pkg.sv
// shared types, constants and helper functions of the angle tracking observer
package atvo_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 5;

  // register indexes on the configuration port
  localparam logic [2:0] REG_BANDWIDTH   = 3'd0;
  localparam logic [2:0] REG_DAMPING     = 3'd1;
  localparam logic [2:0] REG_TORQUE_GAIN = 3'd2;
  localparam logic [2:0] REG_FF_GAIN     = 3'd3;
  localparam logic [2:0] REG_INERTIA     = 3'd4;
  localparam logic [2:0] REG_LOWPASS     = 3'd5;
  localparam logic [2:0] REG_PERIOD      = 3'd6;

  // register reset values
  localparam logic [15:0]        RST_BANDWIDTH   = 16'd1000;
  localparam logic [17:0]        RST_DAMPING     = 18'd58982;
  localparam logic signed [31:0] RST_TORQUE_GAIN = 32'sd65536;
  localparam logic signed [31:0] RST_FF_GAIN     = 32'sd65536;
  localparam logic [31:0]        RST_INERTIA     = 32'd10000;
  localparam logic [16:0]        RST_LOWPASS     = 17'd3873;
  localparam logic [19:0]        RST_PERIOD      = 20'd200000;

  // scaling constants
  localparam logic signed [33:0] TURN_PER_RADNS = 34'sd2935890503;
  localparam logic signed [33:0] TWO_PI_Q29     = 34'sd3373259426;
  localparam logic signed [33:0] NS_Q48         = 34'sd281475;
  localparam logic signed [33:0] ONE_BILLION    = 34'sd1000000000;
  localparam logic signed [33:0] UNITY          = 34'sd1;
  localparam logic [63:0]        QUO_LIMIT      = 64'd140737;
  localparam logic [31:0]        INERTIA_MIN    = 32'd100;
  localparam logic [16:0]        LOWPASS_MAX    = 17'd65536;
  localparam logic [63:0]        LIM62          = 64'h4000_0000_0000_0000;

  localparam logic signed [63:0] SAT48_MAX = 64'sh0000_7fff_ffff_ffff;
  localparam logic signed [63:0] SAT48_MIN = 64'shffff_8000_0000_0000;
  localparam logic signed [63:0] SAT32_MAX = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] SAT32_MIN = 64'shffff_ffff_8000_0000;

  // product shift selection of the shared multiplier
  typedef enum logic [1:0] {
    SH0,
    SH16,
    SH32,
    SH45
  } sh_e;

  // micro operations, issued in this order for each word
  typedef enum logic [4:0] {
    OP_VFF,
    OP_U,
    OP_DPOS1,
    OP_GT,
    OP_DIV1,
    OP_MR,
    OP_DIV2,
    OP_MQ,
    OP_LP,
    OP_WW,
    OP_ERAD,
    OP_M,
    OP_T,
    OP_VEL,
    OP_VOUT,
    OP_K1,
    OP_K2,
    OP_K3,
    OP_DPOS2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic load;
    logic issue;
    logic wb;
    logic out_load;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic done;
  } stat_t;

  function automatic logic op_is_div(input op_e op);
    return (op == OP_DIV1) || (op == OP_DIV2);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x;
    if (x > SAT48_MAX) y = SAT48_MAX;
    if (x < SAT48_MIN) y = SAT48_MIN;
    return y[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x;
    if (x > SAT32_MAX) y = SAT32_MAX;
    if (x < SAT32_MIN) y = SAT32_MIN;
    return y[31:0];
  endfunction

endpackage

>>> rtl/atvo_if.sv
// valid/ready channel interfaces for input and result words
interface atvo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_in;
  logic signed [31:0] torque_in;
  logic signed [31:0] velocity_feedforward;
  logic               enable;

  modport source (output valid, output position_in, output torque_in,
                  output velocity_feedforward, output enable, input ready);
  modport sink   (input valid, input position_in, input torque_in,
                  input velocity_feedforward, input enable, output ready);
endinterface

interface atvo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_out;
  logic signed [31:0] velocity_out;
  logic signed [31:0] accel_out;
  logic signed [31:0] position_error;

  modport source (output valid, output position_out, output velocity_out,
                  output accel_out, output position_error, input ready);
  modport sink   (input valid, input position_out, input velocity_out,
                  input accel_out, input position_error, output ready);
endinterface

>>> rtl/atvo_mul.sv
// shared signed multiplier, 32x33 partial products, truncating shift and clamp
module atvo_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [33:0] b_i,
  input  atvo_pkg::sh_e      sh_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  logic [1:0]         ph_q, ph_d;
  logic               done_q;
  logic               neg_q;
  logic [63:0]        ma_q;
  logic [32:0]        mb_q;
  atvo_pkg::sh_e      sh_q;
  logic [64:0]        plo_q;
  logic [96:0]        prod_q;
  logic signed [63:0] res_q;

  logic [63:0] a_mag;
  logic [33:0] b_mag;
  logic [31:0] half;
  logic [64:0] pp;
  logic [96:0] shifted;
  logic [63:0] mag;

  assign a_mag = a_i[63] ? (64'd0 - a_i) : a_i;
  assign b_mag = b_i[33] ? (34'd0 - b_i) : b_i;
  assign half  = (ph_q == 2'd1) ? ma_q[31:0] : ma_q[63:32];
  assign pp    = {33'd0, half} * {32'd0, mb_q};

  always_comb begin
    case (sh_q)
      atvo_pkg::SH0:  shifted = prod_q;
      atvo_pkg::SH16: shifted = prod_q >> 16;
      atvo_pkg::SH32: shifted = prod_q >> 32;
      atvo_pkg::SH45: shifted = prod_q >> 45;
      default:        shifted = prod_q;
    endcase
    mag = (shifted > {33'd0, atvo_pkg::LIM62}) ? atvo_pkg::LIM62 : shifted[63:0];
  end

  always_comb begin
    ph_d = ph_q;
    if (start_i) begin
      ph_d = 2'd1;
    end else if (ph_q != 2'd0) begin
      ph_d = ph_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= 2'd0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= (ph_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_i[63] ^ b_i[33];
      ma_q  <= a_mag;
      mb_q  <= b_mag[32:0];
      sh_q  <= sh_i;
    end
    if (ph_q == 2'd1) plo_q <= pp;
    if (ph_q == 2'd2) prod_q <= {32'd0, plo_q} + {pp, 32'd0};
    if (ph_q == 2'd3) res_q <= neg_q ? (64'd0 - mag) : mag;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> rtl/atvo_div.sv
// radix-2 restoring divider, 64-bit dividend by 32-bit divisor
module atvo_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quo_o,
  output logic [31:0] rem_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [63:0] quo_q;
  logic [31:0] rem_q;
  logic [31:0] dsr_q;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial = {rem_q, quo_q[63]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= 32'd0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], ge};
      rem_q <= ge ? diff[31:0] : trial[31:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/atvo_dp.sv
// observer datapath: state, scratch registers, operand selection, result register
module atvo_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  atvo_pkg::cmd_t     cmd_i,
  output atvo_pkg::stat_t    stat_o,
  input  logic signed [31:0] position_in_i,
  input  logic signed [31:0] torque_in_i,
  input  logic signed [31:0] velocity_feedforward_i,
  input  logic               enable_i,
  input  logic [15:0]        bandwidth_i,
  input  logic [17:0]        damping_i,
  input  logic signed [31:0] torque_gain_i,
  input  logic signed [31:0] ff_gain_i,
  input  logic [31:0]        inertia_i,
  input  logic [16:0]        lowpass_i,
  input  logic [19:0]        period_i,
  output logic signed [31:0] position_out_o,
  output logic signed [31:0] velocity_out_o,
  output logic signed [31:0] accel_out_o,
  output logic signed [31:0] position_error_o
);

  // observer state
  logic [31:0]        pos_q;
  logic signed [47:0] vel_q;
  logic signed [47:0] fa_q;

  // per-word scratch
  logic [31:0]        pin_q;
  logic signed [31:0] torque_q;
  logic signed [31:0] vff_q;
  logic signed [31:0] vffh_q;
  logic signed [63:0] tmp_q;
  logic [63:0]        mg_q;
  logic               gneg_q;
  logic [63:0]        q_q;
  logic [31:0]        r_q;
  logic signed [47:0] acc_q;
  logic [32:0]        ww_q;
  logic signed [47:0] accff_q;
  logic signed [31:0] vout_q;

  logic signed [31:0] pos_out_q, vel_out_q, acc_out_q, err_out_q;

  logic signed [63:0] mul_a;
  logic signed [33:0] mul_b;
  atvo_pkg::sh_e      mul_sh;
  logic               mul_done, div_done;
  logic signed [63:0] mul_res;
  logic [63:0]        div_dividend;
  logic [63:0]        div_quo;
  logic [31:0]        div_rem;
  logic [31:0]        j_eff;
  logic [16:0]        lp_eff;
  logic [31:0]        err;
  logic signed [63:0] vtot;
  logic signed [63:0] acc_sum;
  logic signed [47:0] acc_mag;
  logic               is_div;

  assign j_eff  = (inertia_i < atvo_pkg::INERTIA_MIN) ? atvo_pkg::INERTIA_MIN : inertia_i;
  assign lp_eff = (lowpass_i > atvo_pkg::LOWPASS_MAX) ? atvo_pkg::LOWPASS_MAX : lowpass_i;
  assign err    = pin_q - pos_q;
  assign vtot   = {{16{vel_q[47]}}, vel_q} + {{16{vffh_q[31]}}, vffh_q, 16'd0};
  assign is_div = atvo_pkg::op_is_div(cmd_i.op);

  always_comb begin
    mul_a  = tmp_q;
    mul_b  = {14'd0, period_i};
    mul_sh = atvo_pkg::SH32;
    div_dividend = mg_q;
    case (cmd_i.op)
      atvo_pkg::OP_VFF: begin
        mul_a  = {{32{vff_q[31]}}, vff_q};
        mul_b  = {{2{ff_gain_i[31]}}, ff_gain_i};
        mul_sh = atvo_pkg::SH16;
      end
      atvo_pkg::OP_U: begin
        mul_a = vtot;
        mul_b = atvo_pkg::TURN_PER_RADNS;
      end
      atvo_pkg::OP_GT: begin
        mul_a  = {{32{torque_gain_i[31]}}, torque_gain_i};
        mul_b  = {{2{torque_q[31]}}, torque_q};
        mul_sh = atvo_pkg::SH16;
      end
      atvo_pkg::OP_DIV1: div_dividend = mg_q;
      atvo_pkg::OP_MR: begin
        mul_a  = {32'd0, r_q};
        mul_b  = atvo_pkg::ONE_BILLION;
        mul_sh = atvo_pkg::SH0;
      end
      atvo_pkg::OP_DIV2: div_dividend = tmp_q;
      atvo_pkg::OP_MQ: begin
        mul_a  = q_q;
        mul_b  = atvo_pkg::ONE_BILLION;
        mul_sh = atvo_pkg::SH0;
      end
      atvo_pkg::OP_LP: begin
        mul_a  = {{16{acc_q[47]}}, acc_q} - {{16{fa_q[47]}}, fa_q};
        mul_b  = {17'd0, lp_eff};
        mul_sh = atvo_pkg::SH16;
      end
      atvo_pkg::OP_WW: begin
        mul_a  = {48'd0, bandwidth_i};
        mul_b  = {18'd0, bandwidth_i};
        mul_sh = atvo_pkg::SH0;
      end
      atvo_pkg::OP_ERAD: begin
        mul_a  = {{32{err[31]}}, err};
        mul_b  = atvo_pkg::TWO_PI_Q29;
        mul_sh = atvo_pkg::SH45;
      end
      atvo_pkg::OP_M: begin
        mul_b  = {1'b0, ww_q};
        mul_sh = atvo_pkg::SH0;
      end
      atvo_pkg::OP_T: begin
        mul_a  = {{16{accff_q[47]}}, accff_q};
        mul_b  = atvo_pkg::NS_Q48;
        mul_sh = atvo_pkg::SH16;
      end
      atvo_pkg::OP_VEL: mul_sh = atvo_pkg::SH16;
      atvo_pkg::OP_VOUT: begin
        mul_a  = {{16{vel_q[47]}}, vel_q};
        mul_b  = atvo_pkg::UNITY;
        mul_sh = atvo_pkg::SH16;
      end
      atvo_pkg::OP_K1: begin
        mul_a  = {{31{err[31]}}, err, 1'b0};
        mul_b  = {16'd0, damping_i};
        mul_sh = atvo_pkg::SH0;
      end
      atvo_pkg::OP_K2: mul_b = atvo_pkg::NS_Q48;
      atvo_pkg::OP_K3: begin
        mul_b  = {18'd0, bandwidth_i};
        mul_sh = atvo_pkg::SH0;
      end
      default: ;
    endcase
  end

  atvo_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.issue && !is_div),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sh_i    (mul_sh),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  atvo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.issue && is_div),
    .dividend_i (div_dividend),
    .divisor_i  (j_eff),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign stat_o.done = mul_done | div_done;

  // torque acceleration: q*1e9 + (r*1e9)/j, saturated once the quotient is too big
  assign acc_sum = mul_res + tmp_q;
  assign acc_mag = (q_q > atvo_pkg::QUO_LIMIT) ? atvo_pkg::SAT48_MAX[47:0]
                                                : atvo_pkg::sat48(acc_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 32'd0;
      vel_q <= 48'sd0;
      fa_q  <= 48'sd0;
    end else begin
      if (cmd_i.load && !enable_i) begin
        pos_q <= position_in_i;
        vel_q <= 48'sd0;
      end
      if (cmd_i.wb) begin
        case (cmd_i.op)
          atvo_pkg::OP_DPOS1, atvo_pkg::OP_DPOS2: pos_q <= pos_q + mul_res[31:0];
          atvo_pkg::OP_LP:  fa_q  <= atvo_pkg::sat48({{16{fa_q[47]}}, fa_q} + mul_res);
          atvo_pkg::OP_VEL: vel_q <= atvo_pkg::sat48({{16{vel_q[47]}}, vel_q} + mul_res);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pin_q    <= position_in_i;
      torque_q <= torque_in_i;
      vff_q    <= velocity_feedforward_i;
    end
    if (cmd_i.wb) begin
      case (cmd_i.op)
        atvo_pkg::OP_VFF: vffh_q <= atvo_pkg::sat32(mul_res);
        atvo_pkg::OP_GT: begin
          mg_q   <= mul_res[63] ? (64'd0 - mul_res) : mul_res;
          gneg_q <= mul_res[63];
        end
        atvo_pkg::OP_DIV1: begin
          q_q <= div_quo;
          r_q <= div_rem;
        end
        atvo_pkg::OP_DIV2: tmp_q <= div_quo;
        atvo_pkg::OP_MQ:   acc_q <= gneg_q ? (48'sd0 - acc_mag) : acc_mag;
        atvo_pkg::OP_WW:   ww_q  <= mul_res[32:0];
        atvo_pkg::OP_M: begin
          accff_q <= atvo_pkg::sat48({{16{acc_q[47]}}, acc_q} - {{16{fa_q[47]}}, fa_q}
                                     + mul_res);
        end
        atvo_pkg::OP_VOUT: vout_q <= atvo_pkg::sat32(mul_res + {{32{vffh_q[31]}}, vffh_q});
        atvo_pkg::OP_U, atvo_pkg::OP_MR, atvo_pkg::OP_ERAD, atvo_pkg::OP_T,
        atvo_pkg::OP_K1, atvo_pkg::OP_K2, atvo_pkg::OP_K3: tmp_q <= mul_res;
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      pos_out_q <= pos_q;
      vel_out_q <= vout_q;
      acc_out_q <= atvo_pkg::sat32({{16{accff_q[47]}}, accff_q});
      err_out_q <= err;
    end
  end

  assign position_out_o   = pos_out_q;
  assign velocity_out_o   = vel_out_q;
  assign accel_out_o      = acc_out_q;
  assign position_error_o = err_out_q;

endmodule

>>> rtl/atvo_ctrl.sv
// sequencer: steps the micro operations of one word and runs the handshakes
module atvo_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  atvo_pkg::stat_t stat_i,
  output atvo_pkg::cmd_t  cmd_o
);

  atvo_pkg::st_e st_q, st_d;
  atvo_pkg::op_e op_q, op_d;
  logic          ovalid_q, ovalid_d;
  logic          out_free;

  assign out_free = !ovalid_q || out_ready_i;

  always_comb begin
    st_d = st_q;
    op_d = op_q;
    case (st_q)
      atvo_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          st_d = atvo_pkg::ST_ISSUE;
          op_d = atvo_pkg::OP_VFF;
        end
      end
      atvo_pkg::ST_ISSUE: st_d = atvo_pkg::ST_WAIT;
      atvo_pkg::ST_WAIT: begin
        if (stat_i.done) begin
          if (op_q == atvo_pkg::OP_DPOS2) begin
            st_d = atvo_pkg::ST_DONE;
          end else begin
            st_d = atvo_pkg::ST_ISSUE;
            op_d = atvo_pkg::op_e'(op_q + 5'd1);
          end
        end
      end
      atvo_pkg::ST_DONE: begin
        if (out_free) st_d = atvo_pkg::ST_IDLE;
      end
      default: st_d = atvo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = op_q;
    in_ready_o     = 1'b0;
    case (st_q)
      atvo_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      atvo_pkg::ST_ISSUE: cmd_o.issue    = 1'b1;
      atvo_pkg::ST_WAIT:  cmd_o.wb       = stat_i.done;
      atvo_pkg::ST_DONE:  cmd_o.out_load = out_free;
      default: ;
    endcase
    ovalid_d = cmd_o.out_load || (ovalid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= atvo_pkg::ST_IDLE;
      op_q     <= atvo_pkg::OP_VFF;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      op_q     <= op_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

>>> rtl/angle_tracking_velocity_observer.sv
// top level: angle tracking velocity observer with configuration registers
//
//   channel   dir  handshake       payload
//   in_i      in   valid/ready     position_in, torque_in, velocity_feedforward, enable
//   out_o     out  valid/ready     position_out, velocity_out, accel_out, position_error
//   apb       in   psel/penable    paddr, pwdata, prdata (7 registers, 4-byte stride)
//
// one word takes 17 passes through the shared multiplier and two 64-step
// divisions in the radix-2 divider
// reset clears the observer state (position, velocity, filtered acceleration)
// and loads the register defaults; no clearing pass is needed
// a finished word waits in the output register; the next input word is taken
// and computed meanwhile, and only its final load waits for the output to drain
module angle_tracking_velocity_observer (
  input  logic        clk_i,
  input  logic        rst_ni,
  atvo_in_if.sink     in_i,
  atvo_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [atvo_pkg::ADDR_W-1:0] paddr,
  input  logic [atvo_pkg::DATA_W-1:0] pwdata,
  output logic [atvo_pkg::DATA_W-1:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [15:0]        bandwidth_q;
  logic [17:0]        damping_q;
  logic signed [31:0] torque_gain_q;
  logic signed [31:0] ff_gain_q;
  logic [31:0]        inertia_q;
  logic [16:0]        lowpass_q;
  logic [19:0]        period_q;

  logic          cfg_wr;
  logic [2:0]    cfg_idx;
  atvo_pkg::cmd_t  cmd;
  atvo_pkg::stat_t stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  // register writes, truncated to each register's width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bandwidth_q   <= atvo_pkg::RST_BANDWIDTH;
      damping_q     <= atvo_pkg::RST_DAMPING;
      torque_gain_q <= atvo_pkg::RST_TORQUE_GAIN;
      ff_gain_q     <= atvo_pkg::RST_FF_GAIN;
      inertia_q     <= atvo_pkg::RST_INERTIA;
      lowpass_q     <= atvo_pkg::RST_LOWPASS;
      period_q      <= atvo_pkg::RST_PERIOD;
    end else if (cfg_wr) begin
      case (cfg_idx)
        atvo_pkg::REG_BANDWIDTH:   bandwidth_q   <= pwdata[15:0];
        atvo_pkg::REG_DAMPING:     damping_q     <= pwdata[17:0];
        atvo_pkg::REG_TORQUE_GAIN: torque_gain_q <= pwdata;
        atvo_pkg::REG_FF_GAIN:     ff_gain_q     <= pwdata;
        atvo_pkg::REG_INERTIA:     inertia_q     <= pwdata;
        atvo_pkg::REG_LOWPASS:     lowpass_q     <= pwdata[16:0];
        atvo_pkg::REG_PERIOD:      period_q      <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // register readback, zero extended
  always_comb begin
    case (cfg_idx)
      atvo_pkg::REG_BANDWIDTH:   prdata = {16'd0, bandwidth_q};
      atvo_pkg::REG_DAMPING:     prdata = {14'd0, damping_q};
      atvo_pkg::REG_TORQUE_GAIN: prdata = torque_gain_q;
      atvo_pkg::REG_FF_GAIN:     prdata = ff_gain_q;
      atvo_pkg::REG_INERTIA:     prdata = inertia_q;
      atvo_pkg::REG_LOWPASS:     prdata = {15'd0, lowpass_q};
      atvo_pkg::REG_PERIOD:      prdata = {12'd0, period_q};
      default:                   prdata = '0;
    endcase
  end

  // sequencer drives the datapath one micro operation at a time
  atvo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath holds the state and the shared multiplier and divider
  atvo_dp u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .stat_o                 (stat),
    .position_in_i          (in_i.position_in),
    .torque_in_i            (in_i.torque_in),
    .velocity_feedforward_i (in_i.velocity_feedforward),
    .enable_i               (in_i.enable),
    .bandwidth_i            (bandwidth_q),
    .damping_i              (damping_q),
    .torque_gain_i          (torque_gain_q),
    .ff_gain_i              (ff_gain_q),
    .inertia_i              (inertia_q),
    .lowpass_i              (lowpass_q),
    .period_i               (period_q),
    .position_out_o         (out_o.position_out),
    .velocity_out_o         (out_o.velocity_out),
    .accel_out_o            (out_o.accel_out),
    .position_error_o       (out_o.position_error)
  );

  // a unit never reports completion the cycle after it was started
  a_issue_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |=> !stat.done)
    else $error("unit finished one cycle after issue");

  // the output register is only reloaded when its word is gone or leaving
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_o.valid || out_o.ready))
    else $error("output word overwritten");

  // an accepted word closes the input until its result is loaded into the output register
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while busy");

endmodule
